// ----- src/hpp_pkg.sv -----
`default_nettype none
package hpp_pkg;

  localparam int CoordW  = 17;
  localparam int SizeW   = 13;
  localparam int ScaleW  = CoordW + SizeW;
  localparam int CoefW   = 32;
  localparam int ProdW   = CoefW + ScaleW + 1;
  localparam int AccW    = 64;
  localparam int QuotW   = 32;
  localparam int FracSh  = 30;
  localparam int AddrW   = 6;
  localparam int DataW   = 64;
  localparam int CamW    = 2 * SizeW;

  typedef enum logic [2:0] {
    RegPair0  = 3'd0,
    RegPair1  = 3'd1,
    RegPair2  = 3'd2,
    RegPair3  = 3'd3,
    RegLast   = 3'd4,
    RegCamera = 3'd5,
    RegFrame  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoefW-1:0] m0;
    logic signed [CoefW-1:0] m1;
    logic signed [CoefW-1:0] m2;
    logic signed [CoefW-1:0] m3;
    logic signed [CoefW-1:0] m4;
    logic signed [CoefW-1:0] m5;
    logic signed [CoefW-1:0] m6;
    logic signed [CoefW-1:0] m7;
    logic signed [CoefW-1:0] m8;
    logic [SizeW-1:0]        cam_w;
    logic [SizeW-1:0]        cam_h;
    logic [SizeW-1:0]        frm_w;
    logic [SizeW-1:0]        frm_h;
  } coef_t;

  typedef struct packed {
    logic [ScaleW-1:0] xs;
    logic [ScaleW-1:0] ys;
    logic              last;
  } point_t;

  typedef struct packed {
    logic [AccW-1:0] u_mag;
    logic [AccW-1:0] v_mag;
    logic [AccW-1:0] w_mag;
    logic            u_neg;
    logic            v_neg;
    logic            w_neg;
    logic            w_zero;
    logic            last;
  } proj_t;

  typedef struct packed {
    logic signed [QuotW-1:0] u;
    logic signed [QuotW-1:0] v;
    logic                    sat;
    logic                    last;
  } result_t;

endpackage
`default_nettype wire

// ----- src/hpp_cfg.sv -----
`default_nettype none
module hpp_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [hpp_pkg::AddrW-1:0] paddr,
  input  wire logic [hpp_pkg::DataW-1:0] pwdata,
  output logic      [hpp_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output hpp_pkg::coef_t                 coef_o
);

  logic [63:0]                  pair0_q, pair1_q, pair2_q, pair3_q;
  logic [hpp_pkg::CoefW-1:0]    last_q;
  logic [hpp_pkg::CamW-1:0]     cam_q, frm_q;
  hpp_pkg::cfg_idx_e            idx;

  assign idx    = hpp_pkg::cfg_idx_e'(paddr[hpp_pkg::AddrW-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair0_q <= 64'd65536;
      pair1_q <= 64'd0;
      pair2_q <= 64'd65536;
      pair3_q <= 64'd0;
      last_q  <= 32'd65536;
      cam_q   <= '0;
      frm_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        hpp_pkg::RegPair0:  pair0_q <= pwdata;
        hpp_pkg::RegPair1:  pair1_q <= pwdata;
        hpp_pkg::RegPair2:  pair2_q <= pwdata;
        hpp_pkg::RegPair3:  pair3_q <= pwdata;
        hpp_pkg::RegLast:   last_q  <= pwdata[hpp_pkg::CoefW-1:0];
        hpp_pkg::RegCamera: cam_q   <= pwdata[hpp_pkg::CamW-1:0];
        hpp_pkg::RegFrame:  frm_q   <= pwdata[hpp_pkg::CamW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hpp_pkg::RegPair0:  prdata = pair0_q;
      hpp_pkg::RegPair1:  prdata = pair1_q;
      hpp_pkg::RegPair2:  prdata = pair2_q;
      hpp_pkg::RegPair3:  prdata = pair3_q;
      hpp_pkg::RegLast:   prdata = {32'd0, last_q};
      hpp_pkg::RegCamera: prdata = {{(hpp_pkg::DataW-hpp_pkg::CamW){1'b0}}, cam_q};
      hpp_pkg::RegFrame:  prdata = {{(hpp_pkg::DataW-hpp_pkg::CamW){1'b0}}, frm_q};
      default:            prdata = '0;
    endcase
  end

  assign coef_o.m0    = pair0_q[31:0];
  assign coef_o.m1    = pair0_q[63:32];
  assign coef_o.m2    = pair1_q[31:0];
  assign coef_o.m3    = pair1_q[63:32];
  assign coef_o.m4    = pair2_q[31:0];
  assign coef_o.m5    = pair2_q[63:32];
  assign coef_o.m6    = pair3_q[31:0];
  assign coef_o.m7    = pair3_q[63:32];
  assign coef_o.m8    = last_q;
  assign coef_o.cam_w = cam_q[hpp_pkg::SizeW-1:0];
  assign coef_o.cam_h = cam_q[hpp_pkg::CamW-1:hpp_pkg::SizeW];
  assign coef_o.frm_w = frm_q[hpp_pkg::SizeW-1:0];
  assign coef_o.frm_h = frm_q[hpp_pkg::CamW-1:hpp_pkg::SizeW];

endmodule
`default_nettype wire

// ----- src/hpp_scale.sv -----
`default_nettype none
module hpp_scale (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [hpp_pkg::CoordW-1:0] x_i,
  input  wire logic [hpp_pkg::CoordW-1:0] y_i,
  input  wire logic                       last_i,
  input  wire hpp_pkg::coef_t             coef_i,
  output logic                            valid_o,
  output hpp_pkg::point_t                 point_o
);

  localparam int W = hpp_pkg::ScaleW;
  localparam int S = hpp_pkg::SizeW;

  // one restoring step: numerator bits shift out the top, quotient bits in at the bottom
  function automatic logic [S+W-1:0] div_step(input logic [S-1:0] rem,
                                              input logic [W-1:0] num,
                                              input logic [S-1:0] den);
    logic [S:0] r2;
    logic [S:0] diff;
    logic       ge;
    r2   = {rem, num[W-1]};
    diff = r2 - {1'b0, den};
    ge   = r2 >= {1'b0, den};
    return {ge ? diff[S-1:0] : r2[S-1:0], num[W-2:0], ge};
  endfunction

  logic         on;
  logic [S-1:0] cw, ch, fw, fh;

  logic         vld_q  [W+1];
  logic         last_q [W+1];
  logic [S-1:0] xr_q   [W+1];
  logic [S-1:0] yr_q   [W+1];
  logic [W-1:0] xn_q   [W+1];
  logic [W-1:0] yn_q   [W+1];

  // rescale off means divide by one after multiplying by one
  assign on = (coef_i.cam_w != '0) && (coef_i.cam_h != '0) &&
              (coef_i.frm_w != '0) && (coef_i.frm_h != '0);
  assign cw = on ? coef_i.cam_w : S'(1);
  assign ch = on ? coef_i.cam_h : S'(1);
  assign fw = on ? coef_i.frm_w : S'(1);
  assign fh = on ? coef_i.frm_h : S'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xn_q[0]   <= W'(x_i) * W'(cw);
      yn_q[0]   <= W'(y_i) * W'(ch);
      xr_q[0]   <= '0;
      yr_q[0]   <= '0;
      last_q[0] <= last_i;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        {xr_q[k+1], xn_q[k+1]} <= div_step(xr_q[k], xn_q[k], fw);
        {yr_q[k+1], yn_q[k+1]} <= div_step(yr_q[k], yn_q[k], fh);
        last_q[k+1]            <= last_q[k];
      end
    end
  end

  assign valid_o      = vld_q[W];
  assign point_o.xs   = xn_q[W];
  assign point_o.ys   = yn_q[W];
  assign point_o.last = last_q[W];

endmodule
`default_nettype wire

// ----- src/hpp_mac.sv -----
`default_nettype none
module hpp_mac (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire hpp_pkg::point_t point_i,
  input  wire hpp_pkg::coef_t  coef_i,
  output logic                 valid_o,
  output hpp_pkg::proj_t       proj_o
);

  localparam int P = hpp_pkg::ProdW;
  localparam int A = hpp_pkg::AccW;

  logic signed [hpp_pkg::ScaleW:0] xs, ys;
  logic signed [P-1:0] pu0_q, pu1_q, pv0_q, pv1_q, pw0_q, pw1_q;
  logic signed [hpp_pkg::CoefW-1:0] m2_q, m5_q, m8_q;
  logic [A-1:0]        u_q, v_q, w_q;
  logic [2:0]          vld_q;
  logic [1:0]          last_q;

  assign xs = $signed({1'b0, point_i.xs});
  assign ys = $signed({1'b0, point_i.ys});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // products
      pu0_q     <= coef_i.m0 * xs;
      pu1_q     <= coef_i.m1 * ys;
      pv0_q     <= coef_i.m3 * xs;
      pv1_q     <= coef_i.m4 * ys;
      pw0_q     <= coef_i.m6 * xs;
      pw1_q     <= coef_i.m7 * ys;
      m2_q      <= coef_i.m2;
      m5_q      <= coef_i.m5;
      m8_q      <= coef_i.m8;
      last_q[0] <= point_i.last;
      // sums: offsets aligned to q.20 and q.34
      u_q <= {pu0_q[P-1], pu0_q} + {pu1_q[P-1], pu1_q} + {{28{m2_q[31]}}, m2_q, 4'd0};
      v_q <= {pv0_q[P-1], pv0_q} + {pv1_q[P-1], pv1_q} + {{28{m5_q[31]}}, m5_q, 4'd0};
      w_q <= {pw0_q[P-1], pw0_q} + {pw1_q[P-1], pw1_q} + {{14{m8_q[31]}}, m8_q, 18'd0};
      last_q[1] <= last_q[0];
      // magnitudes
      proj_o.u_neg  <= u_q[A-1];
      proj_o.v_neg  <= v_q[A-1];
      proj_o.w_neg  <= w_q[A-1];
      proj_o.w_zero <= (w_q == '0);
      proj_o.u_mag  <= u_q[A-1] ? (~u_q + A'(1)) : u_q;
      proj_o.v_mag  <= v_q[A-1] ? (~v_q + A'(1)) : v_q;
      proj_o.w_mag  <= (w_q == '0) ? A'(1) : (w_q[A-1] ? (~w_q + A'(1)) : w_q);
      proj_o.last   <= last_q[1];
    end
  end

  assign valid_o = vld_q[2];

endmodule
`default_nettype wire

// ----- src/hpp_div.sv -----
`default_nettype none
module hpp_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire hpp_pkg::proj_t proj_i,
  output logic                valid_o,
  output hpp_pkg::result_t    res_o
);

  localparam int A = hpp_pkg::AccW;
  localparam int Q = hpp_pkg::QuotW;

  typedef struct packed {
    logic [A-1:0] ur;
    logic [Q-1:0] un;
    logic [A-1:0] vr;
    logic [Q-1:0] vn;
    logic [A-1:0] den;
    logic         u_ovf;
    logic         v_ovf;
    logic         u_neg;
    logic         v_neg;
    logic         w_zero;
    logic         last;
  } div_st_t;

  function automatic logic [A+Q-1:0] div_step(input logic [A-1:0] rem,
                                              input logic [Q-1:0] num,
                                              input logic [A-1:0] den);
    logic [A:0] r2;
    logic [A:0] diff;
    logic       ge;
    r2   = {rem, num[Q-1]};
    diff = r2 - {1'b0, den};
    ge   = r2 >= {1'b0, den};
    return {ge ? diff[A-1:0] : r2[A-1:0], num[Q-2:0], ge};
  endfunction

  // signed clamp of a magnitude quotient to q16.16
  function automatic logic [Q:0] clamp(input logic [Q-1:0] q, input logic ovf,
                                       input logic neg);
    logic [Q:0] r;
    if (neg) begin
      if (ovf || (q > {1'b1, {(Q-1){1'b0}}})) r = {1'b1, 1'b1, {(Q-1){1'b0}}};
      else                                    r = {1'b0, ~q + Q'(1)};
    end else begin
      if (ovf || q[Q-1]) r = {1'b1, 1'b0, {(Q-1){1'b1}}};
      else               r = {1'b0, q};
    end
    return r;
  endfunction

  div_st_t    st_q  [Q+1];
  logic       vld_q [Q+1];
  logic       out_vld_q;
  logic [Q:0] uc, vc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // quotient of at least 2^32 shows up as u_mag >= 4 * w_mag
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].ur     <= {2'b00, proj_i.u_mag[A-1:2]};
      st_q[0].un     <= {proj_i.u_mag[1:0], {hpp_pkg::FracSh{1'b0}}};
      st_q[0].vr     <= {2'b00, proj_i.v_mag[A-1:2]};
      st_q[0].vn     <= {proj_i.v_mag[1:0], {hpp_pkg::FracSh{1'b0}}};
      st_q[0].den    <= proj_i.w_mag;
      st_q[0].u_ovf  <= {2'b00, proj_i.u_mag} >= {proj_i.w_mag, 2'b00};
      st_q[0].v_ovf  <= {2'b00, proj_i.v_mag} >= {proj_i.w_mag, 2'b00};
      st_q[0].u_neg  <= proj_i.u_neg ^ proj_i.w_neg;
      st_q[0].v_neg  <= proj_i.v_neg ^ proj_i.w_neg;
      st_q[0].w_zero <= proj_i.w_zero;
      st_q[0].last   <= proj_i.last;
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        {st_q[k+1].ur, st_q[k+1].un} <= div_step(st_q[k].ur, st_q[k].un, st_q[k].den);
        {st_q[k+1].vr, st_q[k+1].vn} <= div_step(st_q[k].vr, st_q[k].vn, st_q[k].den);
        st_q[k+1].den    <= st_q[k].den;
        st_q[k+1].u_ovf  <= st_q[k].u_ovf;
        st_q[k+1].v_ovf  <= st_q[k].v_ovf;
        st_q[k+1].u_neg  <= st_q[k].u_neg;
        st_q[k+1].v_neg  <= st_q[k].v_neg;
        st_q[k+1].w_zero <= st_q[k].w_zero;
        st_q[k+1].last   <= st_q[k].last;
      end
    end
  end

  assign uc = clamp(st_q[Q].un, st_q[Q].u_ovf, st_q[Q].u_neg);
  assign vc = clamp(st_q[Q].vn, st_q[Q].v_ovf, st_q[Q].v_neg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.u    <= uc[Q-1:0];
      res_o.v    <= vc[Q-1:0];
      res_o.sat  <= uc[Q] | vc[Q] | st_q[Q].w_zero;
      res_o.last <= st_q[Q].last;
    end
  end

  assign valid_o = out_vld_q;

endmodule
`default_nettype wire

// ----- src/homography_point_projection.sv -----
// throughput: one point per cycle while the skid word is empty; the rescale divider (one
// bit per stage) and the w divider (one quotient bit per stage) are fully pipelined
// a two-entry output buffer keeps input open while one result waits
// reset: asynchronous, active low; clears valid bits and loads identity coefficients
`default_nettype none
module homography_point_projection (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [39:0]               s_axis_tdata,  // x_pos, y_pos, zero pad
  input  wire logic                      s_axis_tlast,  // last_point
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [63:0]                    m_axis_tdata,  // u_pos, v_pos
  output logic                           m_axis_tuser,  // saturated
  output logic                           m_axis_tlast,  // end_of_batch
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [hpp_pkg::AddrW-1:0] paddr,
  input  wire logic [hpp_pkg::DataW-1:0] pwdata,
  output logic      [hpp_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  localparam int C = hpp_pkg::CoordW;

  hpp_pkg::coef_t   coef;
  hpp_pkg::point_t  point;
  hpp_pkg::proj_t   proj;
  hpp_pkg::result_t res, out_q, skid_q;
  logic             en, pt_vld, pj_vld, res_vld;
  logic             out_vld_q, skid_vld_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  hpp_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .coef_o (coef)
  );

  hpp_scale u_scale (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .x_i     (s_axis_tdata[C-1:0]),
    .y_i     (s_axis_tdata[2*C-1:C]),
    .last_i  (s_axis_tlast),
    .coef_i  (coef),
    .valid_o (pt_vld),
    .point_o (point)
  );

  hpp_mac u_mac (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (pt_vld),
    .point_i (point),
    .coef_i  (coef),
    .valid_o (pj_vld),
    .proj_o  (proj)
  );

  hpp_div u_div (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (pj_vld),
    .proj_i  (proj),
    .valid_o (res_vld),
    .res_o   (res)
  );

  // output register plus skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= res_vld;
    end else if (res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || m_axis_tready) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.v, out_q.u};
  assign m_axis_tuser  = out_q.sat;
  assign m_axis_tlast  = out_q.last;

endmodule
`default_nettype wire

// ----- src/hpp_checker.sv -----
`default_nettype none
module hpp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed under stall");

  // input closes only when a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // skid word fills only from a blocked output
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input closed without downstream stall");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("config port not ready");

endmodule

bind homography_point_projection hpp_checker u_hpp_checker (.*);
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  class projection_board;
    logic [63:0] pair [4];
    logic [31:0] m8;
    logic [25:0] cam, frm;
    logic [65:0] pending [$];
    int errors;
    int seen;

    function new();
      pair[0] = 64'd65536; pair[1] = 64'd0; pair[2] = 64'd65536; pair[3] = 64'd0;
      m8 = 32'd65536; cam = '0; frm = '0;
      errors = 0; seen = 0;
    endfunction

    function void write_reg(hpp_pkg::cfg_idx_e idx, logic [63:0] val);
      case (idx) inside
        hpp_pkg::RegPair0, hpp_pkg::RegPair1, hpp_pkg::RegPair2, hpp_pkg::RegPair3:
          pair[idx[1:0]] = val;
        hpp_pkg::RegLast: m8 = val[31:0];
        hpp_pkg::RegCamera: cam = val[25:0];
        hpp_pkg::RegFrame: frm = val[25:0];
        default: ;
      endcase
    endfunction

    // magnitude quotient |n|*2^30/|d|, clamped to signed q16.16
    function logic [32:0] finish_div(logic signed [127:0] n, logic wneg,
                                     logic [127:0] wmag);
      logic [127:0] nmag, q;
      logic nneg;
      nneg = n < 0;
      nmag = nneg ? -n : n;
      q = (nmag << 30) / wmag;
      if (nneg != wneg) begin
        if (q > 128'h8000_0000) return {1'b1, 32'h8000_0000};
        return {1'b0, 32'(-q)};
      end
      if (q > 128'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, q[31:0]};
    endfunction

    function void note_point(logic [16:0] x, logic [16:0] y, logic last);
      logic [127:0] xs, ys, wmag;
      logic signed [127:0] u, v, w;
      logic [32:0] ru, rv;
      logic wneg, sat;
      xs = x; ys = y;
      if (cam[12:0] != 0 && cam[25:13] != 0 && frm[12:0] != 0 && frm[25:13] != 0) begin
        xs = (xs * cam[12:0]) / frm[12:0];
        ys = (ys * cam[25:13]) / frm[25:13];
      end
      u = $signed(pair[0][31:0]) * $signed(xs) + $signed(pair[0][63:32]) * $signed(ys)
          + $signed(pair[1][31:0]) * 16;
      v = $signed(pair[1][63:32]) * $signed(xs) + $signed(pair[2][31:0]) * $signed(ys)
          + $signed(pair[2][63:32]) * 16;
      w = $signed(pair[3][31:0]) * $signed(xs) + $signed(pair[3][63:32]) * $signed(ys)
          + $signed(m8) * 262144;
      sat = 0;
      if (w == 0) begin
        wneg = 0; wmag = 1; sat = 1;
      end else begin
        wneg = w < 0; wmag = wneg ? -w : w;
      end
      ru = finish_div(u, wneg, wmag);
      rv = finish_div(v, wneg, wmag);
      sat = sat | ru[32] | rv[32];
      pending.push_back({rv[31:0], ru[31:0], sat, last});
    endfunction

    function void check_word(logic [63:0] data, logic sat, logic last);
      logic [65:0] e;
      seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word u=%h v=%h", $time, data[31:0], data[63:32]);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e[65:2] !== data || e[1] !== sat || e[0] !== last) begin
        $display("%0t: mismatch expected u=%h v=%h sat=%b last=%b, actual u=%h v=%h sat=%b last=%b",
                 $time, e[33:2], e[65:34], e[1], e[0], data[31:0], data[63:32], sat, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tlast = 0, m_axis_tready = 0;
  logic [39:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid, m_axis_tuser, m_axis_tlast;
  logic [63:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [hpp_pkg::AddrW-1:0] paddr = '0;
  logic [hpp_pkg::DataW-1:0] pwdata = '0;
  logic [hpp_pkg::DataW-1:0] prdata;
  logic pready;
  projection_board board;
  int hold_off = 0;
  int sent = 0;

  always #10 clk_i = ~clk_i;

  homography_point_projection dut (.*);

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else if (sent < 200 && sent > 60 && (sent & 63) < 40)
      m_axis_tready <= 1;
    else
      m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic apb_write(hpp_pkg::cfg_idx_e idx, logic [63:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= hpp_pkg::AddrW'(idx * 8); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    board.write_reg(idx, val);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_point(logic [16:0] x, logic [16:0] y, logic last);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, y, x};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_point(x, y, last);
    sent++;
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  task automatic send_burst(int count);
    int left;
    left = count;
    while (left > 0) begin
      repeat ($urandom_range(1, 12)) begin
        if (left > 0) begin
          send_point($urandom_range(0, 131071), $urandom_range(0, 131071), $urandom_range(0, 1));
          left--;
        end
      end
      if ($urandom_range(0, 2) == 0) pause_sender();
    end
    s_axis_tvalid <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef();
    return ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
  endfunction

  initial begin
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // identity, field extremes, zero pad
    send_point(0, 0, 0);
    send_point(17'h1FFFF, 17'h1FFFF, 1);
    send_point(17'h15555, 17'h0AAAA, 0);
    send_point(17'h0AAAA, 17'h15555, 1);
    s_axis_tvalid <= 0;
    drain();
    // zero w
    apb_write(hpp_pkg::RegLast, 64'd0);
    send_point(0, 0, 0);
    send_point(100, 3, 1);
    s_axis_tvalid <= 0;
    drain();
    // clamping both signs, perspective terms
    apb_write(hpp_pkg::RegPair0, {32'h8000_0000, 32'h7FFF_FFFF});
    apb_write(hpp_pkg::RegPair1, {32'h7FFF_FFFF, 32'h8000_0000});
    apb_write(hpp_pkg::RegPair2, {32'h8000_0000, 32'h7FFF_FFFF});
    apb_write(hpp_pkg::RegPair3, {32'h0000_0001, 32'hFFFF_FFFF});
    apb_write(hpp_pkg::RegLast, 64'h0000_0001);
    send_point(17'h1FFFF, 0, 0);
    send_point(0, 17'h1FFFF, 0);
    send_point(1, 1, 1);
    s_axis_tvalid <= 0;
    drain();
    apb_write(hpp_pkg::RegLast, 64'hFFFF_FFFF_8000_0000);
    send_point(17'h1FFFF, 17'h1FFFF, 0);
    s_axis_tvalid <= 0;
    drain();
    // rescale on at extremes
    apb_write(hpp_pkg::RegCamera, 64'h3FF_FFFF);
    apb_write(hpp_pkg::RegFrame, {38'd0, 13'd1, 13'd1});
    send_point(17'h1FFFF, 17'h1FFFF, 0);
    s_axis_tvalid <= 0;
    drain();
    apb_write(hpp_pkg::RegFrame, 64'h3FF_FFFF);
    send_point(17'h1FFFF, 5, 1);
    s_axis_tvalid <= 0;
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      apb_write(hpp_pkg::RegPair0, {rand_coef(), rand_coef()});
      apb_write(hpp_pkg::RegPair1, {rand_coef(), rand_coef()});
      apb_write(hpp_pkg::RegPair2, {rand_coef(), rand_coef()});
      apb_write(hpp_pkg::RegPair3, ph[0] ? {$urandom, $urandom} :
                                   {32'($urandom_range(0, 4095)) - 32'd2048,
                                    32'($urandom_range(0, 4095)) - 32'd2048});
      apb_write(hpp_pkg::RegLast, ph == 3 ? 64'd0 : {32'd0, rand_coef()});
      apb_write(hpp_pkg::RegCamera, ph[1] ? 64'($urandom_range(0, 26'h3FF_FFFF)) : 64'd0);
      apb_write(hpp_pkg::RegFrame, ph == 5 ? 64'd0 : 64'($urandom_range(1, 26'h3FF_FFFF)));
      if (ph == 2) begin
        // long enough that the pipe fills and input stalls during the hold-off
        fork
          hold_off = 300;
          send_burst(120);
        join
      end else
        send_burst(40);
      drain();
    end

    $display("sent %0d points and checked %0d results over eight coefficient phases", sent,
             board.seen);
    $display("covered zero w, clamping, rescale on and off, and a long output stall");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
